@@ rtl/core/voxel_face_visibility_defines.svh @@
// Assertion macros shared by the voxel face visibility RTL.
`ifndef VOXEL_FACE_VISIBILITY_DEFINES_SVH
`define VOXEL_FACE_VISIBILITY_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define VFV_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define VFV_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/vfv_pkg.sv @@
// Shared types and constants of the voxel face visibility block.
package vfv_pkg;

	localparam int COORD_W    = 4;
	localparam int ID_IN_W    = 8;
	localparam int DIR_W      = 3;
	localparam int ACT_W      = 2;
	localparam int CNT_W      = 3;
	localparam int NUM_FACES  = 6;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 24;

	// Item kinds
	localparam logic [ACT_W-1:0] ACT_WR_VOXEL = 2'd0;
	localparam logic [ACT_W-1:0] ACT_WR_OPQ   = 2'd1;
	localparam logic [ACT_W-1:0] ACT_SCAN     = 2'd2;

	// Face directions in test order
	localparam logic [DIR_W-1:0] FACE_BOTTOM = 3'd0;
	localparam logic [DIR_W-1:0] FACE_TOP    = 3'd1;
	localparam logic [DIR_W-1:0] FACE_LEFT   = 3'd2;
	localparam logic [DIR_W-1:0] FACE_RIGHT  = 3'd3;
	localparam logic [DIR_W-1:0] FACE_FRONT  = 3'd4;
	localparam logic [DIR_W-1:0] FACE_BACK   = 3'd5;

	// Neighbor sweep: six reads issued, then the lookup pipeline drains behind them
	localparam logic [CNT_W-1:0] NBR_ISSUE_END = 3'd6;
	localparam logic [CNT_W-1:0] NBR_DONE      = 3'd7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SELF,
		ST_NBR,
		ST_EMIT,
		ST_AIR
	} state_t;

	typedef struct packed {
		logic             accept;
		logic             take_self;
		logic             issue;
		logic [DIR_W-1:0] dir;
		logic             load_air;
		logic             load_face;
	} cmd_t;

	typedef struct packed {
		logic in_scan;
		logic self_air;
		logic mask_zero;
		logic last_face;
		logic out_free;
	} status_t;

endpackage

@@ rtl/core/vfv_ram.sv @@
// Generic single-port RAM with registered read.
module vfv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write on enable, read the addressed word every cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

@@ rtl/core/vfv_ctrl.sv @@
// Controller of the voxel face visibility block: sequences writes, scans and face output.
`include "voxel_face_visibility_defines.svh"

module vfv_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output vfv_pkg::cmd_t    cmd,
	input  vfv_pkg::status_t st
);

	vfv_pkg::state_t state_q, state_d;
	logic [vfv_pkg::CNT_W-1:0] cnt_q, cnt_d;

	// State and sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vfv_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		in_ready = 1'b0;
		cmd.dir  = cnt_q;
		case (state_q)
			vfv_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid && st.in_scan) begin
					state_d = vfv_pkg::ST_SELF;
				end
			end
			vfv_pkg::ST_SELF: begin
				cmd.take_self = 1'b1;
				cnt_d         = '0;
				state_d       = st.self_air ? vfv_pkg::ST_AIR : vfv_pkg::ST_NBR;
			end
			vfv_pkg::ST_NBR: begin
				cmd.issue = (cnt_q < vfv_pkg::NBR_ISSUE_END);
				cnt_d     = cnt_q + 1'b1;
				if (cnt_q == vfv_pkg::NBR_DONE) begin
					state_d = vfv_pkg::ST_EMIT;
				end
			end
			vfv_pkg::ST_EMIT: begin
				if (st.mask_zero) begin
					state_d = vfv_pkg::ST_IDLE;
				end else if (st.out_free) begin
					cmd.load_face = 1'b1;
					if (st.last_face) begin
						state_d = vfv_pkg::ST_IDLE;
					end
				end
			end
			vfv_pkg::ST_AIR: begin
				if (st.out_free) begin
					cmd.load_air = 1'b1;
					state_d      = vfv_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = vfv_pkg::ST_IDLE;
			end
		endcase
	end

	`VFV_ASSERT_IMP(a_load_when_free, cmd.load_air || cmd.load_face, st.out_free, "result loaded into a full output register")
	`VFV_ASSERT_NEXT(a_scan_reads_self, cmd.accept && st.in_scan, state_q == vfv_pkg::ST_SELF, "scan item did not start a self read")
	`VFV_ASSERT_IMP(a_no_accept_busy, cmd.issue || cmd.take_self, !in_ready, "input ready while a scan is at work")

endmodule

@@ rtl/core/vfv_datapath.sv @@
// Datapath of the voxel face visibility block: stores, neighbor lookup, face mask, output register.
`include "voxel_face_visibility_defines.svh"

module vfv_datapath #(
	parameter int SIZE_X  = 16,
	parameter int SIZE_Y  = 16,
	parameter int SIZE_Z  = 16,
	parameter int ID_BITS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [vfv_pkg::ID_IN_W-1:0]      cfg_wr_data,
	input  logic [vfv_pkg::IN_DATA_W-1:0]    in_tdata,
	input  logic [vfv_pkg::ACT_W-1:0]        in_tuser,
	output logic                             out_tvalid,
	input  logic                             out_tready,
	output logic [vfv_pkg::OUT_DATA_W-1:0]   out_tdata,
	output logic [0:0]                       out_tuser,
	output logic                             out_tlast,
	input  vfv_pkg::cmd_t                    cmd,
	output vfv_pkg::status_t                 st
);

	localparam int CELLS = SIZE_X * SIZE_Y * SIZE_Z;
	localparam int AW    = $clog2(CELLS);
	localparam int EXT_W = 9;
	localparam int NF    = vfv_pkg::NUM_FACES;

	localparam logic [AW-1:0]    STRIDE_X = AW'(1);
	localparam logic [AW-1:0]    STRIDE_Y = AW'(SIZE_X);
	localparam logic [AW-1:0]    STRIDE_Z = AW'(SIZE_X * SIZE_Y);
	localparam logic [AW-1:0]    DIM_Y    = AW'(SIZE_Y);
	localparam logic [EXT_W-1:0] LIM_X    = EXT_W'(SIZE_X);
	localparam logic [EXT_W-1:0] LIM_Y    = EXT_W'(SIZE_Y);
	localparam logic [EXT_W-1:0] LIM_Z    = EXT_W'(SIZE_Z);
	localparam logic [EXT_W-1:0] MAX_X    = EXT_W'(SIZE_X - 1);
	localparam logic [EXT_W-1:0] MAX_Y    = EXT_W'(SIZE_Y - 1);
	localparam logic [EXT_W-1:0] MAX_Z    = EXT_W'(SIZE_Z - 1);

	// Input item fields
	logic [vfv_pkg::ACT_W-1:0]   act_in;
	logic [vfv_pkg::COORD_W-1:0] px_in, py_in, pz_in;
	logic [vfv_pkg::ID_IN_W-1:0] blk_in;
	logic                        opq_in;
	logic                        in_chunk_in;
	logic [AW-1:0]               addr_in;

	logic [vfv_pkg::ID_IN_W-1:0] air_q;
	logic [ID_BITS-1:0]          air_w;

	logic [vfv_pkg::COORD_W-1:0] pos_x_q, pos_y_q, pos_z_q;
	logic [AW-1:0]               base_q;
	logic                        self_ok_q;
	logic [ID_BITS-1:0]          self_id_q;
	logic [ID_BITS-1:0]          self_val;

	logic [EXT_W-1:0]            ex_x, ex_y, ex_z;
	logic                        nbr_in;
	logic [AW-1:0]               nbr_addr;

	logic                        vox_we;
	logic [AW-1:0]               vox_addr;
	logic [ID_BITS-1:0]          vox_rd;
	logic                        opq_we;
	logic [ID_BITS-1:0]          opq_addr;
	logic                        opq_rd;

	logic                        valid_s1, in_s1;
	logic                        valid_s2, in_s2;
	logic [ID_BITS-1:0]          adj_s2;
	logic                        emit_bit;

	logic [NF-1:0]               mask_q;
	logic [NF-1:0]               sel_hot;
	logic [NF-1:0]               mask_rest;
	logic [vfv_pkg::DIR_W-1:0]   sel_dir;
	logic                        found;

	logic                        out_valid_q;
	logic                        out_vis_q;
	logic                        out_last_q;
	logic [vfv_pkg::DIR_W-1:0]   out_dir_q;
	logic [vfv_pkg::COORD_W-1:0] out_x_q, out_y_q, out_z_q;
	logic [vfv_pkg::ID_IN_W-1:0] out_blk_q;

	// Unpack the input item
	assign act_in = in_tuser;
	assign px_in  = in_tdata[3:0];
	assign py_in  = in_tdata[7:4];
	assign pz_in  = in_tdata[11:8];
	assign blk_in = in_tdata[19:12];
	assign opq_in = in_tdata[20];

	assign in_chunk_in = (EXT_W'(px_in) < LIM_X) && (EXT_W'(py_in) < LIM_Y)
		&& (EXT_W'(pz_in) < LIM_Z);
	assign addr_in = AW'(px_in) + STRIDE_Y * (AW'(py_in) + DIM_Y * AW'(pz_in));

	// Air id register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			air_q <= '0;
		end else if (cfg_wr_en) begin
			air_q <= cfg_wr_data;
		end
	end
	assign air_w = ID_BITS'(air_q);

	// Hold the item's position and cell address
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pos_x_q   <= px_in;
			pos_y_q   <= py_in;
			pos_z_q   <= pz_in;
			base_q    <= addr_in;
			self_ok_q <= in_chunk_in;
		end
		if (cmd.take_self) begin
			self_id_q <= self_val;
		end
	end

	// A voxel outside the chunk reads as air
	assign self_val = self_ok_q ? vox_rd : air_w;

	// Neighbor address and chunk bounds for the current direction
	assign ex_x = EXT_W'(pos_x_q);
	assign ex_y = EXT_W'(pos_y_q);
	assign ex_z = EXT_W'(pos_z_q);

	always_comb begin
		nbr_in   = 1'b0;
		nbr_addr = base_q;
		case (cmd.dir)
			vfv_pkg::FACE_BOTTOM: begin
				nbr_in   = (ex_y != '0);
				nbr_addr = base_q - STRIDE_Y;
			end
			vfv_pkg::FACE_TOP: begin
				nbr_in   = (ex_y != MAX_Y);
				nbr_addr = base_q + STRIDE_Y;
			end
			vfv_pkg::FACE_LEFT: begin
				nbr_in   = (ex_x != '0);
				nbr_addr = base_q - STRIDE_X;
			end
			vfv_pkg::FACE_RIGHT: begin
				nbr_in   = (ex_x != MAX_X);
				nbr_addr = base_q + STRIDE_X;
			end
			vfv_pkg::FACE_FRONT: begin
				nbr_in   = (ex_z != MAX_Z);
				nbr_addr = base_q + STRIDE_Z;
			end
			vfv_pkg::FACE_BACK: begin
				nbr_in   = (ex_z != '0);
				nbr_addr = base_q - STRIDE_Z;
			end
			default: begin
				nbr_in   = 1'b0;
				nbr_addr = base_q;
			end
		endcase
	end

	// Voxel store: write items and all scan reads share the one port
	assign vox_we   = cmd.accept && (act_in == vfv_pkg::ACT_WR_VOXEL) && in_chunk_in;
	assign vox_addr = cmd.issue ? nbr_addr : addr_in;

	vfv_ram #(
		.WIDTH (ID_BITS),
		.DEPTH (CELLS)
	) u_voxel_ram (
		.clk   (clk),
		.we    (vox_we),
		.addr  (vox_addr),
		.wdata (ID_BITS'(blk_in)),
		.rdata (vox_rd)
	);

	// Opacity table: looked up with the neighbor id in the cycle after its read
	assign opq_we   = cmd.accept && (act_in == vfv_pkg::ACT_WR_OPQ);
	assign opq_addr = valid_s1 ? vox_rd : ID_BITS'(blk_in);

	vfv_ram #(
		.WIDTH (1),
		.DEPTH (2 ** ID_BITS)
	) u_opacity_ram (
		.clk   (clk),
		.we    (opq_we),
		.addr  (opq_addr),
		.wdata (opq_in),
		.rdata (opq_rd)
	);

	// Neighbor lookup pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
		end
	end

	// Neighbor lookup pipeline payload
	always_ff @(posedge clk) begin
		in_s1  <= nbr_in;
		in_s2  <= in_s1;
		adj_s2 <= vox_rd;
	end

	// Face shows past the chunk edge, against air, or against a clear block of another id
	assign emit_bit = !in_s2 || (adj_s2 == air_w) || (!opq_rd && (adj_s2 != self_id_q));

	// Pick the lowest pending face
	always_comb begin
		sel_dir = '0;
		sel_hot = '0;
		found   = 1'b0;
		for (int i = 0; i < NF; i++) begin
			if (mask_q[i] && !found) begin
				sel_dir    = vfv_pkg::DIR_W'(i);
				sel_hot[i] = 1'b1;
				found      = 1'b1;
			end
		end
	end
	assign mask_rest = mask_q & ~sel_hot;

	// Face mask: shift in one verdict per direction, drop each face as it goes out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (cmd.accept) begin
			mask_q <= '0;
		end else if (valid_s2) begin
			mask_q <= {emit_bit, mask_q[NF-1:1]};
		end else if (cmd.load_face) begin
			mask_q <= mask_rest;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_air || cmd.load_face) begin
			out_valid_q <= 1'b1;
		end else if (out_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.load_air || cmd.load_face) begin
			out_vis_q  <= cmd.load_face;
			out_dir_q  <= cmd.load_face ? sel_dir : vfv_pkg::FACE_BOTTOM;
			out_last_q <= cmd.load_face ? st.last_face : 1'b1;
			out_x_q    <= pos_x_q;
			out_y_q    <= pos_y_q;
			out_z_q    <= pos_z_q;
			out_blk_q  <= vfv_pkg::ID_IN_W'(self_id_q);
		end
	end

	assign out_tvalid = out_valid_q;
	assign out_tdata  = {1'b0, out_blk_q, out_z_q, out_y_q, out_x_q, out_dir_q};
	assign out_tuser  = out_vis_q;
	assign out_tlast  = out_last_q;

	// Status to the controller
	assign st.in_scan   = (act_in == vfv_pkg::ACT_SCAN);
	assign st.self_air  = (self_val == air_w);
	assign st.mask_zero = (mask_q == '0);
	assign st.last_face = (mask_rest == '0);
	assign st.out_free  = !out_valid_q || out_tready;

	`VFV_ASSERT_IMP(a_face_needs_mask, cmd.load_face, mask_q != '0, "face loaded with no face pending")
	`VFV_ASSERT_NEXT(a_last_clears_mask, cmd.load_face && st.last_face, mask_q == '0, "faces left after the last one")
	`VFV_ASSERT_IMP(a_no_shift_on_emit, valid_s2, !cmd.load_face && !cmd.accept, "mask shifted while faces go out")

endmodule

@@ rtl/core/voxel_face_visibility.sv @@
// Voxel face visibility: top level joining the controller and the datapath.
// Write items (voxel id, opacity bit) and unused kinds are taken back to back while idle.
// A scan of air (or of a position outside the chunk) loads one air result; a solid voxel
// reads its six neighbors and their opacity, then emits its visible faces back to back, or
// none if all are hidden. No item is taken until a scan ends. The single voxel memory port,
// read for the voxel and each neighbor, serializes the reads; back-pressure stalls results.
// The stores need no clearing pass after reset and read undefined until written; air_id
// resets to 0. The user must write air_id only while idle; the block does not enforce this.
module voxel_face_visibility #(
	parameter int SIZE_X  = 16,
	parameter int SIZE_Y  = 16,
	parameter int SIZE_Z  = 16,
	parameter int ID_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,   // air_id
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // pos_x, pos_y, pos_z, block_id, opaque, zero pad
	input  logic [1:0]  s_axis_tuser,  // action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // face_dir, out_x, out_y, out_z, face_block, zero pad
	output logic [0:0]  m_axis_tuser,  // visible
	output logic        m_axis_tlast   // last
);

	vfv_pkg::cmd_t    cmd;
	vfv_pkg::status_t st;

	vfv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.cmd      (cmd),
		.st       (st)
	);

	vfv_datapath #(
		.SIZE_X  (SIZE_X),
		.SIZE_Y  (SIZE_Y),
		.SIZE_Z  (SIZE_Z),
		.ID_BITS (ID_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_tdata    (s_axis_tdata),
		.in_tuser    (s_axis_tuser),
		.out_tvalid  (m_axis_tvalid),
		.out_tready  (m_axis_tready),
		.out_tdata   (m_axis_tdata),
		.out_tuser   (m_axis_tuser),
		.out_tlast   (m_axis_tlast),
		.cmd         (cmd),
		.st          (st)
	);

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the voxel face visibility block.
`timescale 1ns / 1ps

module tb_top;
	import vfv_pkg::*;

	localparam int CHUNK_DIM = 16;
	localparam int CELL_COUNT = CHUNK_DIM * CHUNK_DIM * CHUNK_DIM;
	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
	// Wait that outlasts the longest quiet spell of the block: a solid voxel with every face culled
	localparam int SETTLE_CYCLES = 20;
	localparam int PHASE_ITEMS = 20;

	typedef struct {
		logic [ACT_W-1:0] action;
		logic [3:0]       x;
		logic [3:0]       y;
		logic [3:0]       z;
		logic [7:0]       id;
		logic             opaque;
	} voxel_cmd_t;

	typedef struct packed {
		logic             visible;
		logic [DIR_W-1:0] dir;
		logic [3:0]       x;
		logic [3:0]       y;
		logic [3:0]       z;
		logic [7:0]       block;
		logic             last;
	} face_item_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [7:0]  cfg_wr_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;   // pos_x, pos_y, pos_z, block_id, opaque, zero pad
	logic [1:0]  s_axis_tuser;   // action
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;   // face_dir, out_x, out_y, out_z, face_block, zero pad
	logic [0:0]  m_axis_tuser;   // visible
	logic        m_axis_tlast;

	// Shadow copy of the chunk, the opacity table and air_id
	logic [7:0]  chunk_ids [CELL_COUNT];
	bit          chunk_known [CELL_COUNT];
	bit          opacity_bits [256];
	bit          opacity_known [256];
	logic [7:0]  air_id_q;

	face_item_t  faces_due [$];
	logic [11:0] scene_sites [$];
	logic [7:0]  palette [4];
	int          mismatches;
	int          items_counted;
	int          send_idle_pct;
	int          recv_stall_pct;
	int          recv_hold_req;
	int          recv_hold_left;

	voxel_face_visibility dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("voxel_face_visibility: mismatch");
		$finish;
	end

	// Step one face from a voxel; report whether the neighbor lies inside the chunk
	function automatic bit face_neighbor(input logic [3:0] x, y, z,
			input logic [DIR_W-1:0] dir, output logic [3:0] nx, ny, nz);
		int ix;
		int iy;
		int iz;
		ix = int'(x);
		iy = int'(y);
		iz = int'(z);
		case (dir)
			FACE_BOTTOM: iy--;
			FACE_TOP:    iy++;
			FACE_LEFT:   ix--;
			FACE_RIGHT:  ix++;
			FACE_FRONT:  iz++;
			FACE_BACK:   iz--;
			default: ;
		endcase
		nx = ix[3:0];
		ny = iy[3:0];
		nz = iz[3:0];
		return ix >= 0 && ix < CHUNK_DIM && iy >= 0 && iy < CHUNK_DIM
			&& iz >= 0 && iz < CHUNK_DIM;
	endfunction

	// A scan may only touch entries that were written
	function automatic bit scan_safe(input logic [3:0] x, y, z);
		logic [3:0] nx;
		logic [3:0] ny;
		logic [3:0] nz;
		logic [11:0] slot;
		if (!chunk_known[{z, y, x}])
			return 1'b0;
		if (chunk_ids[{z, y, x}] == air_id_q)
			return 1'b1;
		for (int d = 0; d < NUM_FACES; d++) begin
			if (face_neighbor(x, y, z, d[DIR_W-1:0], nx, ny, nz)) begin
				slot = {nz, ny, nx};
				if (!chunk_known[slot] || !opacity_known[chunk_ids[slot]])
					return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	// Update the shadow state for one accepted item and queue the faces it shows
	function automatic void predict_faces(input voxel_cmd_t c);
		logic [11:0] slot;
		logic [7:0]  self_id;
		logic [7:0]  adj;
		logic [3:0]  nx;
		logic [3:0]  ny;
		logic [3:0]  nz;
		bit          show;
		face_item_t  found [$];
		slot = {c.z, c.y, c.x};
		case (c.action)
			ACT_WR_VOXEL: begin
				chunk_ids[slot] = c.id;
				chunk_known[slot] = 1'b1;
			end
			ACT_WR_OPQ: begin
				opacity_bits[c.id] = c.opaque;
				opacity_known[c.id] = 1'b1;
			end
			ACT_SCAN: begin
				self_id = chunk_ids[slot];
				if (self_id == air_id_q) begin
					faces_due.push_back({1'b0, FACE_BOTTOM, c.x, c.y, c.z, self_id, 1'b1});
				end else begin
					for (int d = 0; d < NUM_FACES; d++) begin
						if (!face_neighbor(c.x, c.y, c.z, d[DIR_W-1:0], nx, ny, nz)) begin
							show = 1'b1;
						end else begin
							adj = chunk_ids[{nz, ny, nx}];
							show = adj == air_id_q || (!opacity_bits[adj] && adj != self_id);
						end
						if (show)
							found.push_back({1'b1, d[DIR_W-1:0], c.x, c.y, c.z, self_id, 1'b0});
					end
					if (found.size() > 0)
						found[found.size() - 1].last = 1'b1;
					foreach (found[i])
						faces_due.push_back(found[i]);
				end
			end
			default: ;
		endcase
	endfunction

	// Offer one item, hold it until accepted, then predict
	task automatic send_item(input voxel_cmd_t c);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {3'b000, c.opaque, c.id, c.z, c.y, c.x};
		s_axis_tuser <= c.action;
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		predict_faces(c);
		if (c.action != ACT_UNUSED)
			items_counted++;
	endtask

	task automatic put_voxel(input logic [3:0] x, y, z, input logic [7:0] id);
		send_item('{ACT_WR_VOXEL, x, y, z, id, 1'($urandom_range(0, 1))});
	endtask

	task automatic put_opacity(input logic [7:0] id, input logic opaque);
		send_item('{ACT_WR_OPQ, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
			4'($urandom_range(0, 15)), id, opaque});
	endtask

	task automatic scan_voxel(input logic [3:0] x, y, z);
		send_item('{ACT_SCAN, x, y, z, 8'($urandom_range(0, 255)),
			1'($urandom_range(0, 1))});
	endtask

	// Drop valid and hold until every queued face has come back
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do begin
			@(posedge clk);
		end while (faces_due.size() != 0);
	endtask

	// Write air_id once the block has gone quiet
	task automatic set_air(input logic [7:0] value);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		air_id_q = value;
	endtask

	function automatic logic [3:0] pick_coord();
		case ($urandom_range(0, 9))
			0: return 4'd0;
			1: return 4'd15;
			default: return 4'($urandom_range(0, 15));
		endcase
	endfunction

	// Bias ids toward air, the voxel's own id and a few shared ids
	function automatic logic [7:0] pick_id(input logic [7:0] own);
		case ($urandom_range(0, 11))
			0, 1: return air_id_q;
			2, 3: return own;
			4, 5, 6, 7: return palette[2'($urandom_range(0, 3))];
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Ignored kinds and stray opacity writes between scene writes
	task automatic send_noise();
		if ($urandom_range(0, 1))
			send_item('{ACT_UNUSED, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
				4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
				1'($urandom_range(0, 1))});
		else
			put_opacity(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	// Build a voxel and its neighborhood with random content, then scan it if every entry it touches is known
	task automatic build_scene();
		logic [3:0]  x;
		logic [3:0]  y;
		logic [3:0]  z;
		logic [3:0]  nx;
		logic [3:0]  ny;
		logic [3:0]  nz;
		logic [7:0]  self_id;
		logic [11:0] site;
		x = pick_coord();
		y = pick_coord();
		z = pick_coord();
		if (!chunk_known[{z, y, x}] || $urandom_range(0, 3) != 0)
			put_voxel(x, y, z, pick_id(palette[2'($urandom_range(0, 3))]));
		self_id = chunk_ids[{z, y, x}];
		for (int d = 0; d < NUM_FACES; d++) begin
			if (face_neighbor(x, y, z, d[DIR_W-1:0], nx, ny, nz)) begin
				if (!chunk_known[{nz, ny, nx}] || $urandom_range(0, 1))
					put_voxel(nx, ny, nz, pick_id(self_id));
				if ($urandom_range(0, 9) == 0)
					send_noise();
			end
		end
		for (int d = 0; d < NUM_FACES; d++) begin
			if (face_neighbor(x, y, z, d[DIR_W-1:0], nx, ny, nz)) begin
				if (!opacity_known[chunk_ids[{nz, ny, nx}]] || $urandom_range(0, 3) == 0)
					put_opacity(chunk_ids[{nz, ny, nx}], 1'($urandom_range(0, 1)));
			end
		end
		if (!opacity_known[self_id])
			put_opacity(self_id, 1'($urandom_range(0, 1)));
		if (scan_safe(x, y, z)) begin
			scan_voxel(x, y, z);
			scene_sites.push_back({z, y, x});
		end
		// Revisit earlier scenes
		repeat ($urandom_range(0, 2)) begin
			site = scene_sites[$urandom_range(0, scene_sites.size() - 1)];
			if (scan_safe(site[3:0], site[7:4], site[11:8]))
				scan_voxel(site[3:0], site[7:4], site[11:8]);
		end
	endtask

	// Corners, an air voxel, an ignored kind and a fully hidden voxel
	task automatic test_directed_faces();
		logic [3:0] nx;
		logic [3:0] ny;
		logic [3:0] nz;
		set_air(8'h00);
		put_opacity(8'h00, 1'b0);
		put_opacity(8'hFF, 1'b1);
		put_opacity(8'h81, 1'b0);
		// Low corner: out-of-chunk, air, opaque and see-through neighbors
		put_voxel(4'd0, 4'd0, 4'd0, 8'hFF);
		put_voxel(4'd1, 4'd0, 4'd0, 8'hFF);
		put_voxel(4'd0, 4'd1, 4'd0, 8'h00);
		put_voxel(4'd0, 4'd0, 4'd1, 8'h81);
		scan_voxel(4'd0, 4'd0, 4'd0);
		scan_voxel(4'd0, 4'd1, 4'd0);
		send_item('{ACT_UNUSED, 4'hF, 4'hF, 4'hF, 8'hFF, 1'b1});
		// High corner: see-through neighbor of the same id is culled
		put_voxel(4'd15, 4'd15, 4'd15, 8'h81);
		put_voxel(4'd14, 4'd15, 4'd15, 8'h81);
		put_voxel(4'd15, 4'd14, 4'd15, 8'hFF);
		put_voxel(4'd15, 4'd15, 4'd14, 8'hFF);
		scan_voxel(4'd15, 4'd15, 4'd15);
		// Interior voxel boxed in by opaque blocks shows nothing
		put_voxel(4'd1, 4'd1, 4'd1, 8'h81);
		for (int d = 0; d < NUM_FACES; d++) begin
			if (face_neighbor(4'd1, 4'd1, 4'd1, d[DIR_W-1:0], nx, ny, nz))
				put_voxel(nx, ny, nz, 8'hFF);
		end
		scan_voxel(4'd1, 4'd1, 4'd1);
	endtask

	// Moving air_id turns stored solids into air and exposes hidden faces
	task automatic test_air_id_change();
		set_air(8'hFF);
		scan_voxel(4'd0, 4'd0, 4'd0);
		scan_voxel(4'd1, 4'd1, 4'd1);
		scan_voxel(4'd15, 4'd15, 4'd15);
	endtask

	task automatic test_random_scenes();
		int          idle_pct [4];
		int          stall_pct [4];
		logic [7:0]  air_vals [4];
		int          start;
		idle_pct = '{0, 61, 0, 7};
		stall_pct = '{0, 0, 61, 7};
		air_vals = '{8'($urandom_range(1, 254)), 8'hFF, 8'h00, 8'($urandom_range(0, 255))};
		palette = '{8'h00, 8'hFF, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
		for (int p = 0; p < 4; p++) begin
			set_air(air_vals[p]);
			send_idle_pct = idle_pct[p];
			recv_stall_pct = stall_pct[p];
			start = items_counted;
			while (items_counted - start < PHASE_ITEMS)
				build_scene();
		end
	endtask

	// Hold the output for a long stretch so the block fills and stalls its input
	task automatic test_backpressure();
		logic [11:0] site;
		wait_drained();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		recv_hold_req = 400;
		repeat (16) begin
			site = scene_sites[$urandom_range(0, scene_sites.size() - 1)];
			if (scan_safe(site[3:0], site[7:4], site[11:8]))
				scan_voxel(site[3:0], site[7:4], site[11:8]);
		end
		wait_drained();
		recv_stall_pct = 30;
		repeat (3) build_scene();
	endtask

	// Check each face result and drive the output ready
	always @(posedge clk) begin : face_checker
		face_item_t got;
		face_item_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = {m_axis_tuser[0], m_axis_tdata[2:0], m_axis_tdata[6:3],
					m_axis_tdata[10:7], m_axis_tdata[14:11], m_axis_tdata[22:15],
					m_axis_tlast};
				if (faces_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected face item: got %p", got);
				end else begin
					want = faces_due.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("face item differs: expected %p got %p", want, got);
					end
				end
			end
			if (recv_hold_req > 0) begin
				recv_hold_left = recv_hold_req;
				recv_hold_req = 0;
			end
			if (recv_hold_left > 0) begin
				recv_hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= $urandom_range(0, 99) >= recv_stall_pct;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= 8'h00;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= ACT_WR_VOXEL;
		m_axis_tready <= 1'b0;
		air_id_q = 8'h00;
		mismatches = 0;
		items_counted = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		recv_hold_req = 0;
		recv_hold_left = 0;
		palette = '{8'h00, 8'hFF, 8'h81, 8'h3C};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_faces();
		test_air_id_change();
		test_random_scenes();
		test_backpressure();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && faces_due.size() == 0)
			$display("voxel_face_visibility: match");
		else
			$display("voxel_face_visibility: mismatch");
		$finish;
	end

endmodule
